FILE: rtl/bpc_pkg.sv
package bpc_pkg;

  typedef struct packed {
    logic signed [20:0] temp_term;
    logic [18:0]        raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pressure;
    logic        divide_by_zero;
  } out_item_t;

  // Register indexes.
  typedef enum logic [2:0] {
    REG_A1 = 3'd0,
    REG_A2 = 3'd1,
    REG_A3 = 3'd2,
    REG_A4 = 3'd3,
    REG_B1 = 3'd4,
    REG_B2 = 3'd5,
    REG_OSS = 3'd6
  } reg_idx_t;

  localparam int unsigned QuotW = 32;
  localparam logic [31:0] TempOffset = 32'd4000;
  localparam logic [31:0] SensBias = 32'd32768;
  localparam logic [31:0] ScaleBase = 32'd50000;
  localparam logic [31:0] TopBit = 32'h8000_0000;

  // One divider cell's data, handed along the chain every cycle.
  typedef struct packed {
    logic        vld;
    logic [32:0] rem;
    logic [31:0] num;
    logic [31:0] quo;
    logic [31:0] den;
    logic        late_dbl;
    logic        dbz;
  } div_cell_t;

endpackage

FILE: rtl/bpc_front.sv
// Fixed-point front end: five registered stages build the offset, the
// sensitivity and the scaled difference b7, at most one multiply level per stage.
module bpc_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  bpc_pkg::in_item_t      in_item,
  input  logic [15:0]            a1,
  input  logic [15:0]            a2,
  input  logic [15:0]            a3,
  input  logic [15:0]            a4,
  input  logic [15:0]            b1,
  input  logic [15:0]            b2,
  input  logic [1:0]             oss,
  output bpc_pkg::div_cell_t     cell_o
);

  logic [4:0]  vld_r;
  // Stage 1 results.
  logic [31:0] d1_r;
  logic [18:0] up1_r;
  // Stage 2.
  logic [31:0] sq2_r, ad2_r, a3d2_r;
  logic [18:0] up2_r;
  // Stage 3.
  logic [31:0] x1o3_r, x2s3_r, ad3_r, a3d3_r;
  logic [18:0] up3_r;
  // Stage 4.
  logic [31:0] off4_r, x3s4_r;
  logic [18:0] up4_r;
  // Stage 5.
  logic [31:0] sens5_r, b7_5_r;

  logic [31:0] d_nxt, off_nxt, x3_nxt, x3o, sens_nxt, b7_nxt, dd;
  logic [31:0] a1x, a2x, a3x, b1x, b2x, a4x;

  assign a1x = {{16{a1[15]}}, a1};
  assign a2x = {{16{a2[15]}}, a2};
  assign a3x = {{16{a3[15]}}, a3};
  assign b1x = {{16{b1[15]}}, b1};
  assign b2x = {{16{b2[15]}}, b2};
  assign a4x = {16'd0, a4};

  assign d_nxt = {{11{in_item.temp_term[20]}}, in_item.temp_term} - bpc_pkg::TempOffset;
  assign dd = d1_r * d1_r;
  assign x3o = ((a1x << 2) + x1o3_r + ad3_r) << oss;
  assign off_nxt = 32'($signed(x3o + 32'd2) >>> 2);
  assign x3_nxt = 32'($signed(a3d3_r + x2s3_r + 32'd2) >>> 2);
  assign sens_nxt = (a4x * (x3s4_r + bpc_pkg::SensBias)) >> 15;
  assign b7_nxt = ({13'd0, up4_r} - off4_r) * (bpc_pkg::ScaleBase >> oss);

  // Valid pipe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  // Datapath stages.
  always_ff @(posedge clk) begin
    d1_r   <= d_nxt;
    up1_r  <= in_item.raw_pressure;
    sq2_r  <= 32'($signed(dd) >>> 12);
    ad2_r  <= a2x * d1_r;
    a3d2_r <= a3x * d1_r;
    up2_r  <= up1_r;
    x1o3_r <= 32'($signed(b2x * sq2_r) >>> 11);
    x2s3_r <= 32'($signed(b1x * sq2_r) >>> 16);
    ad3_r  <= 32'($signed(ad2_r) >>> 11);
    a3d3_r <= 32'($signed(a3d2_r) >>> 13);
    up3_r  <= up2_r;
    off4_r <= off_nxt;
    x3s4_r <= x3_nxt;
    up4_r  <= up3_r;
    sens5_r <= sens_nxt;
    b7_5_r  <= b7_nxt;
  end

  // First cell input: pre-doubled numerator unless b7 has its top bit set.
  always_comb begin
    cell_o.vld = vld_r[4];
    cell_o.rem = '0;
    cell_o.quo = '0;
    cell_o.den = sens5_r;
    cell_o.dbz = (sens5_r == 32'd0);
    cell_o.late_dbl = (b7_5_r >= bpc_pkg::TopBit);
    cell_o.num = cell_o.late_dbl ? b7_5_r : (b7_5_r << 1);
  end

endmodule

FILE: rtl/bpc_div_cell.sv
// One restoring-division cell: retires one quotient bit per cycle.
module bpc_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  bpc_pkg::div_cell_t cell_i,
  output bpc_pkg::div_cell_t cell_o
);

  bpc_pkg::div_cell_t c_nxt, c_r;
  logic [32:0] trial, diff;

  always_comb begin
    trial = {cell_i.rem[31:0], cell_i.num[31]};
    diff = trial - {1'b0, cell_i.den};
    c_nxt = cell_i;
    c_nxt.num = cell_i.num << 1;
    if (!diff[32]) begin
      c_nxt.rem = diff;
      c_nxt.quo = {cell_i.quo[30:0], 1'b1};
    end else begin
      c_nxt.rem = trial;
      c_nxt.quo = {cell_i.quo[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.vld <= 1'b0;
    end else begin
      c_r.vld <= c_nxt.vld;
    end
    c_r.rem <= c_nxt.rem;
    c_r.num <= c_nxt.num;
    c_r.quo <= c_nxt.quo;
    c_r.den <= c_nxt.den;
    c_r.late_dbl <= c_nxt.late_dbl;
    c_r.dbz <= c_nxt.dbz;
  end

  assign cell_o = c_r;

endmodule

FILE: rtl/barometric_pressure_compensation.sv
// Pressure compensation pipeline. One reading is taken every cycle (start is
// honored whenever busy is low, and busy stays low). Each result appears on
// out_item with out_strobe high for one cycle, after its start has passed
// through five front-end stages, a chain of 32 divider cells that each yield
// one quotient bit, and one output register. Results cannot be held off.
module barometric_pressure_compensation (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  bpc_pkg::in_item_t     in_item,
  output logic                  out_strobe,
  output bpc_pkg::out_item_t    out_item,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  logic [15:0] a1_r, a2_r, a3_r, a4_r, b1_r, b2_r;
  logic [1:0]  oss_r;
  bpc_pkg::div_cell_t chain [0:bpc_pkg::QuotW];
  bpc_pkg::div_cell_t last;
  logic strobe_r;
  bpc_pkg::out_item_t item_r;

  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_r <= '0; a2_r <= '0; a3_r <= '0; a4_r <= '0;
      b1_r <= '0; b2_r <= '0; oss_r <= '0;
    end else if (cfg_we) begin
      case (bpc_pkg::reg_idx_t'(cfg_index))
        bpc_pkg::REG_A1:  a1_r <= cfg_data;
        bpc_pkg::REG_A2:  a2_r <= cfg_data;
        bpc_pkg::REG_A3:  a3_r <= cfg_data;
        bpc_pkg::REG_A4:  a4_r <= cfg_data;
        bpc_pkg::REG_B1:  b1_r <= cfg_data;
        bpc_pkg::REG_B2:  b2_r <= cfg_data;
        bpc_pkg::REG_OSS: oss_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  bpc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_vld(start && !busy), .in_item(in_item),
    .a1(a1_r), .a2(a2_r), .a3(a3_r), .a4(a4_r), .b1(b1_r), .b2(b2_r),
    .oss(oss_r), .cell_o(chain[0])
  );

  // Divider cell chain.
  for (genvar i = 0; i < bpc_pkg::QuotW; i++) begin : g_cell
    bpc_div_cell u_cell (
      .clk(clk), .rst_n(rst_n), .cell_i(chain[i]), .cell_o(chain[i+1])
    );
  end

  assign last = chain[bpc_pkg::QuotW];

  // Output register with final doubling and zero-divisor handling.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= last.vld;
    end
    if (last.dbz) begin
      item_r.pressure <= '1;
    end else if (last.late_dbl) begin
      item_r.pressure <= last.quo << 1;
    end else begin
      item_r.pressure <= last.quo;
    end
    item_r.divide_by_zero <= last.dbz;
  end

  assign out_strobe = strobe_r;
  assign out_item = item_r;

  // Every strobed result must trace back to a start that entered the pipeline.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start, 38)) else $error("result without start");
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.divide_by_zero |-> out_item.pressure == 32'hFFFF_FFFF)
    else $error("zero divisor result not all ones");
  a_chain: assert property (@(posedge clk) disable iff (!rst_n)
    chain[0].vld |=> chain[1].vld) else $error("chain lost item");

endmodule

FILE: sim/barometric_pressure_compensation_test.sv
module barometric_pressure_compensation_test;

  // An index past the end of the register list; writes to it are dropped.
  localparam logic [2:0] RegUnused = 3'd7;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainCycles = 45;

  // Expected pressure words with the calibration that produces them.
  class pressure_scoreboard;
    logic [31:0] a1, a2, a3, a4, b1, b2;
    logic [1:0] mode;
    bpc_pkg::out_item_t pending_words[$];
    int unsigned failures;

    function new();
      clear_regs();
      failures = 0;
    endfunction

    function void clear_regs();
      a1 = '0; a2 = '0; a3 = '0; a4 = '0; b1 = '0; b2 = '0; mode = '0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        bpc_pkg::REG_A1: a1 = {{16{val[15]}}, val};
        bpc_pkg::REG_A2: a2 = {{16{val[15]}}, val};
        bpc_pkg::REG_A3: a3 = {{16{val[15]}}, val};
        bpc_pkg::REG_A4: a4 = {16'd0, val};
        bpc_pkg::REG_B1: b1 = {{16{val[15]}}, val};
        bpc_pkg::REG_B2: b2 = {{16{val[15]}}, val};
        bpc_pkg::REG_OSS: mode = val[1:0];
        default: ;
      endcase
    endfunction

    // Works out the compensated pressure with 32-bit wrapping arithmetic.
    function bpc_pkg::out_item_t compensate(bpc_pkg::in_item_t it);
      logic [31:0] t, up, d, prod, sq, x1, x2, x3, tmp, off, sens, b7;
      bpc_pkg::out_item_t res;
      t = {{11{it.temp_term[20]}}, it.temp_term};
      up = {13'd0, it.raw_pressure};
      d = t - bpc_pkg::TempOffset;
      prod = d * d;
      sq = $signed(prod) >>> 12;
      prod = b2 * sq;
      x1 = $signed(prod) >>> 11;
      prod = a2 * d;
      x2 = $signed(prod) >>> 11;
      x3 = x1 + x2;
      tmp = ((a1 * 32'd4 + x3) << mode) + 32'd2;
      off = $signed(tmp) >>> 2;
      prod = a3 * d;
      x1 = $signed(prod) >>> 13;
      prod = b1 * sq;
      x2 = $signed(prod) >>> 16;
      tmp = x1 + x2 + 32'd2;
      x3 = $signed(tmp) >>> 2;
      prod = a4 * (x3 + bpc_pkg::SensBias);
      sens = prod >> 15;
      b7 = (up - off) * (bpc_pkg::ScaleBase >> mode);
      if (sens == 32'd0) begin
        res.pressure = 32'hFFFF_FFFF;
        res.divide_by_zero = 1'b1;
      end else begin
        if (b7 < bpc_pkg::TopBit) res.pressure = (b7 << 1) / sens;
        else res.pressure = (b7 / sens) << 1;
        res.divide_by_zero = 1'b0;
      end
      return res;
    endfunction

    function void note_reading(bpc_pkg::in_item_t it);
      pending_words.push_back(compensate(it));
    endfunction

    function void check_result(bpc_pkg::out_item_t got);
      bpc_pkg::out_item_t exp_word;
      if (pending_words.size() == 0) begin
        $error("unexpected result: pressure %h dbz %b", got.pressure, got.divide_by_zero);
        failures++;
        return;
      end
      exp_word = pending_words.pop_front();
      if (got.pressure !== exp_word.pressure) begin
        $error("pressure: expected %h, actual %h", exp_word.pressure, got.pressure);
        failures++;
      end
      if (got.divide_by_zero !== exp_word.divide_by_zero) begin
        $error("divide_by_zero: expected %b, actual %b",
               exp_word.divide_by_zero, got.divide_by_zero);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  bpc_pkg::in_item_t in_item = '0;
  logic out_strobe;
  bpc_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  pressure_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned idle_pct = 0;

  barometric_pressure_compensation i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Every strobed result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_item);
  end

  // Hard stop in case results never arrive.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One reading transfer, with random gaps before it.
  task automatic send_reading(bpc_pkg::in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note_reading(it);
  endtask

  // Stops the input and waits until every expected result has come back.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Writes all calibration registers, plus a dropped write past the list.
  task automatic load_calibration(logic [15:0] v[7]);
    for (int i = 0; i < 7; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data <= v[i];
      @(posedge clk);
      sb.set_reg(i[2:0], v[i]);
    end
    @(negedge clk);
    cfg_index <= RegUnused;
    cfg_data <= 16'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic bpc_pkg::in_item_t make_reading(logic [20:0] t, logic [18:0] up);
    bpc_pkg::in_item_t it;
    it.temp_term = t;
    it.raw_pressure = up;
    return it;
  endfunction

  function automatic bpc_pkg::in_item_t random_reading();
    logic [20:0] t;
    logic [18:0] up;
    case ($urandom_range(3))
      0: t = 21'($urandom);
      1: t = 21'(32'($urandom_range(8000)) - 32'd2000);
      2: t = $urandom_range(1) ? 21'h0F_FFFF : 21'h10_0000;
      default: t = 21'(32'($urandom_range(16000)) - 32'd8000);
    endcase
    up = $urandom_range(1) ? 19'($urandom) : 19'($urandom_range(20000, 120000));
    return make_reading(t, up);
  endfunction

  function automatic logic [15:0] random_coef();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] cal[7];
    logic [20:0] temps[5];
    logic [18:0] raws[3];
    int unsigned sent;
    temps = '{21'h10_0000, 21'h0F_FFFF, 21'd0, 21'd4000, 21'h1F_FFFF};
    raws = '{19'd0, 19'h7_FFFF, 19'd23843};

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset calibration: the sensitivity is zero, so every result flags it.
    send_reading(make_reading(21'd4000, 19'd23843));
    send_reading(make_reading(21'h10_0000, 19'h7_FFFF));
    drain();

    // Typical calibration through all four oversampling modes.
    for (int m = 0; m < 4; m++) begin
      cal = '{16'd408, 16'hFFB8, 16'hC7D1, 16'd32741, 16'd6190, 16'd4, 16'(m)};
      load_calibration(cal);
      for (int k = 0; k < 5; k++) send_reading(make_reading(temps[k], raws[k % 3]));
      drain();
    end

    // Random calibration phases, idling pattern changing by thirds.
    sent = 0;
    for (int ph = 0; ph < 11; ph++) begin
      for (int i = 0; i < 6; i++) cal[i] = random_coef();
      cal[6] = 16'($urandom);
      if (ph == 1) cal = '{16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'h8000, 16'h8000, 16'd3};
      if (ph == 2) cal = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'd0};
      load_calibration(cal);
      for (int i = 0; i < 100; i++) begin
        idle_pct = (sent < 360) ? 38 : (sent < 720) ? 69 : 0;
        send_reading(random_reading());
        sent++;
      end
      drain();
    end

    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
